[hdl/dpf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the point evaluation block.
// No dependencies; used by every module under hdl except dpf_ram.
package dpf_pkg;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_ROOT_LO = 3'd0;
  localparam logic [2:0] REG_ROOT_HI = 3'd1;
  localparam logic [2:0] REG_PARTY   = 3'd2;
  localparam logic [2:0] REG_DEPTH   = 3'd3;
  localparam logic [2:0] REG_MODULUS = 3'd4;
  localparam logic [2:0] REG_FCORR   = 3'd5;

  localparam logic [63:0] GOLDEN  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] GOLDEN2 = 64'h3C6EF372FE94F82A;
  localparam logic [63:0] GOLDEN3 = 64'hDAA66D2C7DDF743F;
  localparam logic [63:0] MIX1    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX2    = 64'h94D049BB133111EB;
  localparam logic [63:0] DOM_LO  = 64'hA24BAED4963EE407;
  localparam logic [63:0] DOM_HI  = 64'h9FB21C651E98DF25;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // PRG output words of one expansion
  localparam logic [1:0] W_SEED_LO = 2'd0;
  localparam logic [1:0] W_SEED_HI = 2'd1;
  localparam logic [1:0] W_TAG_A   = 2'd2;
  localparam logic [1:0] W_TAG_B   = 2'd3;

  // operands of the leaf reductions
  localparam logic [1:0] RED_LO = 2'd0;
  localparam logic [1:0] RED_HI = 2'd1;
  localparam logic [1:0] RED_FC = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  level_index;
    logic [63:0] corr_seed_low;
    logic [63:0] corr_seed_high;
    logic        corr_bit_left;
    logic        corr_bit_right;
    logic [31:0] eval_point;
  } in_item_t;

  typedef struct packed {
    logic [63:0] share_value;
    logic [31:0] point_echo;
  } out_item_t;

  typedef struct packed {
    logic [63:0] root_seed_low;
    logic [63:0] root_seed_high;
    logic        party_id;
    logic [5:0]  tree_depth;
    logic [63:0] ring_modulus;
    logic [63:0] final_correction;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LVL_CHK,
    ST_INIT,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_X27,
    ST_FIN,
    ST_LEVEL,
    ST_RED_LOAD,
    ST_RED_STEP,
    ST_RED_SAVE,
    ST_ADD_SEED,
    ST_ADD_CORR,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE,
    OP_START,
    OP_MIX_INIT,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_XOR27,
    OP_FINISH,
    OP_LEVEL,
    OP_RED_LOAD,
    OP_RED_STEP,
    OP_RED_SAVE,
    OP_ADD_SEED,
    OP_ADD_CORR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] word;
    logic [1:0] red_sel;
    logic       mix2;
  } dp_cmd_t;

  typedef struct packed {
    logic levels_done;
  } dp_status_t;

endpackage

[hdl/dpf_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/dpf_cfg_regs.sv]
`timescale 1ns / 1ps
// APB-style configuration registers of the point evaluation block.
// Depends on dpf_pkg.
module dpf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpf_pkg::PADDR_W-1:0] paddr,
  input  logic [dpf_pkg::PDATA_W-1:0] pwdata,
  output logic [dpf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output dpf_pkg::cfg_t               cfg
);
  import dpf_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ROOT_LO: cfg_nxt.root_seed_low    = pwdata;
        REG_ROOT_HI: cfg_nxt.root_seed_high   = pwdata;
        REG_PARTY:   cfg_nxt.party_id         = pwdata[0];
        REG_DEPTH:   cfg_nxt.tree_depth       = pwdata[5:0];
        REG_MODULUS: cfg_nxt.ring_modulus     = pwdata;
        REG_FCORR:   cfg_nxt.final_correction = pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROOT_LO: prdata = cfg_r.root_seed_low;
      REG_ROOT_HI: prdata = cfg_r.root_seed_high;
      REG_PARTY:   prdata = {63'b0, cfg_r.party_id};
      REG_DEPTH:   prdata = {58'b0, cfg_r.tree_depth};
      REG_MODULUS: prdata = cfg_r.ring_modulus;
      REG_FCORR:   prdata = cfg_r.final_correction;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.root_seed_low    <= '0;
      cfg_r.root_seed_high   <= '0;
      cfg_r.party_id         <= 1'b0;
      cfg_r.tree_depth       <= 6'd1;
      cfg_r.ring_modulus     <= '1;
      cfg_r.final_correction <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/dpf_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences the PRG expansion, the level walk and the leaf
// reductions, and owns both handshakes. Depends on dpf_pkg.
module dpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  output logic                out_valid,
  input  logic                out_ready,
  output dpf_pkg::dp_cmd_t    cmd,
  input  dpf_pkg::dp_status_t status
);
  import dpf_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  word_r, word_nxt;
  logic [1:0]  red_r, red_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        mix2_r, mix2_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    red_nxt       = red_r;
    cnt_nxt       = cnt_r;
    mix2_nxt      = mix2_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_req_type == REQ_EVAL) begin
          state_nxt = ST_LVL_CHK;
        end
      end
      ST_LVL_CHK: begin
        if (status.levels_done) begin
          red_nxt   = RED_LO;
          state_nxt = ST_RED_LOAD;
        end else begin
          word_nxt  = W_SEED_LO;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        mix2_nxt  = 1'b0;
        state_nxt = ST_MUL_LL;
      end
      ST_MUL_LL: state_nxt = ST_MUL_LH;
      ST_MUL_LH: state_nxt = ST_MUL_HL;
      ST_MUL_HL: state_nxt = mix2_r ? ST_FIN : ST_X27;
      ST_X27: begin
        mix2_nxt  = 1'b1;
        state_nxt = ST_MUL_LL;
      end
      ST_FIN: begin
        if (word_r == W_TAG_B) begin
          state_nxt = ST_LEVEL;
        end else begin
          word_nxt  = word_r + 2'd1;
          state_nxt = ST_INIT;
        end
      end
      ST_LEVEL: state_nxt = ST_LVL_CHK;
      ST_RED_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = ST_RED_STEP;
      end
      ST_RED_STEP: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_RED_SAVE;
        end
      end
      ST_RED_SAVE: begin
        if (red_r == RED_FC) begin
          state_nxt = ST_ADD_SEED;
        end else begin
          red_nxt   = red_r + 2'd1;
          state_nxt = ST_RED_LOAD;
        end
      end
      ST_ADD_SEED: state_nxt = ST_ADD_CORR;
      ST_ADD_CORR: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.op      = OP_NOP;
    cmd.word    = word_r;
    cmd.red_sel = red_r;
    cmd.mix2    = mix2_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = (in_req_type == REQ_EVAL) ? OP_START : OP_WRITE;
        end
      end
      ST_INIT:     cmd.op = OP_MIX_INIT;
      ST_MUL_LL:   cmd.op = OP_MUL_LL;
      ST_MUL_LH:   cmd.op = OP_MUL_LH;
      ST_MUL_HL:   cmd.op = OP_MUL_HL;
      ST_X27:      cmd.op = OP_XOR27;
      ST_FIN:      cmd.op = OP_FINISH;
      ST_LEVEL:    cmd.op = OP_LEVEL;
      ST_RED_LOAD: cmd.op = OP_RED_LOAD;
      ST_RED_STEP: cmd.op = OP_RED_STEP;
      ST_RED_SAVE: cmd.op = OP_RED_SAVE;
      ST_ADD_SEED: cmd.op = OP_ADD_SEED;
      ST_ADD_CORR: cmd.op = OP_ADD_CORR;
      ST_OUT:      cmd.op = out_free ? OP_OUT : OP_NOP;
      default:     cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      word_r      <= W_SEED_LO;
      red_r       <= RED_LO;
      cnt_r       <= '0;
      mix2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      red_r       <= red_nxt;
      cnt_r       <= cnt_nxt;
      mix2_r      <= mix2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/dpf_datapath.sv]
`timescale 1ns / 1ps
// Datapath: seed and control bit, splitmix mixer on one 32x32 multiplier,
// bit-serial remainder unit, modular add and the correction table.
// Depends on dpf_pkg and dpf_ram.
module dpf_datapath #(
  parameter int MAX_LEVELS = 32
) (
  input  logic                 clk,
  input  dpf_pkg::in_item_t    in_data,
  input  dpf_pkg::cfg_t        cfg,
  input  dpf_pkg::dp_cmd_t     cmd,
  output dpf_pkg::dp_status_t  status,
  output dpf_pkg::out_item_t   out_data
);
  import dpf_pkg::*;

  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LC_W  = $clog2(MAX_LEVELS + 1);
  localparam int ENT_W = 130;

  function automatic logic [63:0] mod_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (m != 64'd0 && (s >= {1'b0, m})) begin
      s = s - {1'b0, m};
    end
    return s[63:0];
  endfunction

  logic [63:0]      slo_r, shi_r, nlo_r, nhi_r;
  logic             t_r;
  logic [1:0]       tag_r;
  logic [63:0]      z_r, acc_r;
  logic [LC_W-1:0]  lvl_r, depth_r;
  logic [31:0]      point_r;
  logic [63:0]      rem_r, dvd_r, va_r, vb_r, vc_r, v_r;
  out_item_t        out_r;

  logic [ENT_W-1:0] ram_rdata;
  logic             ram_we;
  logic [5:0]       max6, depth_sat, pos6;
  logic             cur_bit;
  logic [63:0]      a_w, b_w, st_w, kc, fin_w;
  logic [31:0]      ma, mb;
  logic [63:0]      prod;
  logic [64:0]      rem_sh;
  logic [63:0]      red_src;
  logic             nt;

  assign max6      = 6'(MAX_LEVELS);
  assign depth_sat = (cfg.tree_depth > max6) ? max6 : cfg.tree_depth;
  assign ram_we    = (cmd.op == OP_WRITE) && ({1'b0, in_data.level_index} < max6);

  dpf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LEVELS)
  ) u_corr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (LVL_W'(in_data.level_index)),
    .wdata ({in_data.corr_bit_right, in_data.corr_bit_left,
             in_data.corr_seed_high, in_data.corr_seed_low}),
    .raddr (LVL_W'(lvl_r)),
    .rdata (ram_rdata)
  );

  assign status.levels_done = (lvl_r == depth_r);

  // point bit for this level, most significant first; positions past 31 read 0
  assign pos6    = 6'(depth_r) - 6'(lvl_r) - 6'd1;
  assign cur_bit = pos6[5] ? 1'b0 : point_r[pos6[4:0]];

  assign a_w = slo_r ^ DOM_LO;
  assign b_w = shi_r ^ DOM_HI;

  always_comb begin
    case (cmd.word)
      W_SEED_LO: st_w = (cur_bit ? b_w : a_w) + GOLDEN;
      W_SEED_HI: st_w = (cur_bit ? b_w : a_w) + GOLDEN2;
      W_TAG_A:   st_w = a_w + GOLDEN3;
      default:   st_w = b_w + GOLDEN3;
    endcase
  end

  // 64x64 low product in three partial products
  assign kc = cmd.mix2 ? MIX2 : MIX1;
  always_comb begin
    case (cmd.op)
      OP_MUL_LH: begin ma = z_r[31:0];  mb = kc[63:32]; end
      OP_MUL_HL: begin ma = z_r[63:32]; mb = kc[31:0];  end
      default:   begin ma = z_r[31:0];  mb = kc[31:0];  end
    endcase
  end
  assign prod  = 64'(ma) * 64'(mb);
  assign fin_w = acc_r ^ (acc_r >> 31);

  assign rem_sh = {rem_r, dvd_r[63]};

  always_comb begin
    case (cmd.red_sel)
      RED_LO:  red_src = slo_r;
      RED_HI:  red_src = shi_r;
      default: red_src = cfg.final_correction;
    endcase
  end

  assign nt = (cur_bit ? tag_r[1] : tag_r[0]) ^ (t_r & ram_rdata[128 + 32'(cur_bit)]);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        slo_r   <= cfg.root_seed_low;
        shi_r   <= cfg.root_seed_high;
        t_r     <= cfg.party_id;
        lvl_r   <= '0;
        depth_r <= LC_W'(depth_sat);
        point_r <= in_data.eval_point;
      end
      OP_MIX_INIT: z_r <= st_w ^ (st_w >> 30);
      OP_MUL_LL:   acc_r <= prod;
      OP_MUL_LH,
      OP_MUL_HL:   acc_r <= acc_r + {prod[31:0], 32'b0};
      OP_XOR27:    z_r <= acc_r ^ (acc_r >> 27);
      OP_FINISH: begin
        case (cmd.word)
          W_SEED_LO: nlo_r <= fin_w;
          W_SEED_HI: nhi_r <= fin_w;
          W_TAG_A:   tag_r <= fin_w[1:0];
          default:   tag_r <= tag_r ^ fin_w[1:0];
        endcase
      end
      OP_LEVEL: begin
        slo_r <= t_r ? (nlo_r ^ ram_rdata[63:0])   : nlo_r;
        shi_r <= t_r ? (nhi_r ^ ram_rdata[127:64]) : nhi_r;
        t_r   <= nt;
        lvl_r <= lvl_r + LC_W'(1);
      end
      OP_RED_LOAD: begin
        dvd_r <= red_src;
        rem_r <= '0;
      end
      OP_RED_STEP: begin
        // a zero modulus subtracts zero at every step, leaving the operand itself
        rem_r <= (rem_sh >= {1'b0, cfg.ring_modulus}) ?
                 64'(rem_sh - {1'b0, cfg.ring_modulus}) : rem_sh[63:0];
        dvd_r <= {dvd_r[62:0], 1'b0};
      end
      OP_RED_SAVE: begin
        case (cmd.red_sel)
          RED_LO:  va_r <= rem_r;
          RED_HI:  vb_r <= rem_r;
          default: vc_r <= rem_r;
        endcase
      end
      OP_ADD_SEED: v_r <= mod_add(va_r, vb_r, cfg.ring_modulus);
      OP_ADD_CORR: begin
        if (t_r) begin
          v_r <= mod_add(v_r, vc_r, cfg.ring_modulus);
        end
      end
      OP_OUT: begin
        out_r.share_value <= (cfg.party_id && v_r != 64'd0) ?
                             (cfg.ring_modulus - v_r) : v_r;
        out_r.point_echo  <= point_r;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

[hdl/dpf_point_evaluation.sv]
`timescale 1ns / 1ps
// Top level of the distributed point function evaluator.
// Depends on dpf_pkg, dpf_cfg_regs, dpf_ctrl, dpf_datapath, dpf_ram.
//
// Usage:
//  - Configure root seed, party, depth, modulus and final correction over the
//    APB port (64-bit registers at byte address 8*index) while idle.
//  - Input channel (in_valid/in_ready/in_data): a write item stores one
//    level's correction words as it is accepted; it gives no result.
//  - An evaluate item yields one result item (share, echoed point) on
//    out_valid/out_ready/out_data.
//  - The time an evaluate item takes, accept to out_valid, is set by the shared
//    32x32 multiplier (four splitmix words per level, each two 64-bit products in
//    three passes) and the bit-serial remainder unit (three reductions at the
//    leaf). One item is in work at a time, so no item is taken until the last
//    evaluate item has reached the output register.
//  - A finished result waits in the output register; a new item is accepted
//    while it waits, and the next result holds until it has been taken.
//  - rst_n (synchronous, active low) restores register defaults and empties
//    the output; the correction table is not cleared and must be written
//    before levels that use it are evaluated.
module dpf_point_evaluation #(
  parameter int MAX_LEVELS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dpf_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dpf_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpf_pkg::PADDR_W-1:0] paddr,
  input  logic [dpf_pkg::PDATA_W-1:0] pwdata,
  output logic [dpf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import dpf_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  dpf_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_data.req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status)
  );

  dpf_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[bench/dpf_point_checker.sv]
`timescale 1ns / 1ps
// Checker for dpf_point_evaluation: follows register and table writes, predicts
// each share and compares results in order. Depends on dpf_pkg.
module dpf_point_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  dpf_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  dpf_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [dpf_pkg::PADDR_W-1:0] paddr,
  input  logic [dpf_pkg::PDATA_W-1:0] pwdata,
  output int                          errors,
  output int                          pending
);
  import dpf_pkg::*;

  logic [63:0] seed_lo_reg, seed_hi_reg, modulus_reg, fcorr_reg;
  logic        party_reg;
  logic [5:0]  depth_reg;
  logic [63:0] corr_lo [32];
  logic [63:0] corr_hi [32];
  logic [1:0]  corr_bits [32];
  out_item_t   shares_due [$];

  function automatic logic [63:0] splitmix(inout logic [63:0] st);
    logic [63:0] z;
    st = st + GOLDEN;
    z = st;
    z = (z ^ (z >> 30)) * MIX1;
    z = (z ^ (z >> 27)) * MIX2;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] mod_red(logic [63:0] a, logic [63:0] m);
    return (m == 0) ? a : a % m;
  endfunction

  function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (m == 0) return s[63:0];
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  function automatic logic [63:0] share_at(logic [31:0] point);
    logic [63:0] slo, shi, a, b, k0, k1, k2, k3, tag, v;
    logic        t, nt, bitv;
    int          depth, pos;
    depth = (depth_reg > 32) ? 32 : int'(depth_reg);
    slo = seed_lo_reg;
    shi = seed_hi_reg;
    t = party_reg;
    for (int i = 0; i < depth; i++) begin
      a = slo ^ DOM_LO;
      b = shi ^ DOM_HI;
      k0 = splitmix(a);
      k1 = splitmix(a);
      k2 = splitmix(b);
      k3 = splitmix(b);
      tag = splitmix(a);
      tag = tag ^ splitmix(b);
      pos = depth - 1 - i;
      bitv = point[pos];
      if (!bitv) begin
        slo = k0; shi = k1; nt = tag[0];
      end else begin
        slo = k2; shi = k3; nt = tag[1];
      end
      if (t) begin
        slo = slo ^ corr_lo[i];
        shi = shi ^ corr_hi[i];
        nt = nt ^ corr_bits[i][bitv];
      end
      t = nt;
    end
    v = mod_add(mod_red(slo, modulus_reg), mod_red(shi, modulus_reg), modulus_reg);
    if (t) v = mod_add(v, mod_red(fcorr_reg, modulus_reg), modulus_reg);
    if (party_reg && v != 0) v = modulus_reg - v;
    return v;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;
  assign pending = shares_due.size();

  always @(posedge clk) begin
    out_item_t want;
    out_item_t due;
    if (!rst_n) begin
      seed_lo_reg <= '0;
      seed_hi_reg <= '0;
      party_reg   <= 1'b0;
      depth_reg   <= 6'd1;
      modulus_reg <= '1;
      fcorr_reg   <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_ROOT_LO: seed_lo_reg <= pwdata;
          REG_ROOT_HI: seed_hi_reg <= pwdata;
          REG_PARTY:   party_reg   <= pwdata[0];
          REG_DEPTH:   depth_reg   <= pwdata[5:0];
          REG_MODULUS: modulus_reg <= pwdata;
          REG_FCORR:   fcorr_reg   <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_WRITE) begin
          corr_lo[in_data.level_index]   <= in_data.corr_seed_low;
          corr_hi[in_data.level_index]   <= in_data.corr_seed_high;
          corr_bits[in_data.level_index] <= {in_data.corr_bit_right, in_data.corr_bit_left};
        end else begin
          due.share_value = share_at(in_data.eval_point);
          due.point_echo  = in_data.eval_point;
          shares_due.insert(shares_due.size(), due);
        end
      end
      if (out_valid && out_ready) begin
        if (shares_due.size() == 0) begin
          report("unexpected item", out_data.share_value, '0);
        end else begin
          want = shares_due.pop_front();
          if (out_data.share_value !== want.share_value)
            report("share_value", out_data.share_value, want.share_value);
          if (out_data.point_echo !== want.point_echo)
            report("point_echo", out_data.point_echo, want.point_echo);
        end
      end
    end
  end
endmodule

[bench/dpf_point_evaluation_tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for dpf_point_evaluation: fills the correction table, then runs
// phases of configuration and items. Depends on it, dpf_pkg, dpf_point_checker.
module dpf_point_evaluation_tb;
  import dpf_pkg::*;

  localparam int RUN_LIMIT = 3_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int                  errors, pending;
  int                  cycles = 0;
  int                  burst_left = 0;
  bit                  hold_req = 0;

  always #2 clk = ~clk;

  dpf_point_evaluation uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dpf_point_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("dpf_point_evaluation_tb NOT OK");
      $finish;
    end
  end

  // receiver: stall pattern redrawn from three modes; long hold-off on request
  always @(posedge clk) begin
    int hold_cnt, mode_left, mode;
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 3000;
    end
    if (mode_left <= 0) begin
      mode = $urandom_range(0, 2);
      mode_left = 200;
    end
    mode_left--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (mode == 0) begin
      out_ready <= 1'b1;
    end else if (mode == 1) begin
      out_ready <= 1'($urandom_range(0, 1));
    end else begin
      out_ready <= ($urandom_range(0, 9) == 0);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t level_item(logic [4:0] lvl);
    in_item_t it;
    it = '{req_type: REQ_WRITE, level_index: lvl, corr_seed_low: rand64(),
           corr_seed_high: rand64(), corr_bit_left: 1'($urandom_range(0, 1)),
           corr_bit_right: 1'($urandom_range(0, 1)), eval_point: $urandom};
    return it;
  endfunction

  function automatic in_item_t eval_item(logic [31:0] point);
    in_item_t it;
    it = level_item(5'($urandom_range(0, 31)));
    it.req_type = REQ_EVAL;
    it.eval_point = point;
    return it;
  endfunction

  function automatic in_item_t random_item();
    return ($urandom_range(0, 9) < 6) ? eval_item($urandom)
                                      : level_item(5'($urandom_range(0, 31)));
  endfunction

  task automatic run_phase(logic [63:0] root_lo, logic [63:0] root_hi, logic party,
                           logic [5:0] depth, logic [63:0] modulus, logic [63:0] fcorr,
                           int n, bit hold);
    reg_write(REG_ROOT_LO, root_lo);
    reg_write(REG_ROOT_HI, root_hi);
    reg_write(REG_PARTY, {63'd0, party});
    reg_write(REG_DEPTH, {58'd0, depth});
    reg_write(REG_MODULUS, modulus);
    reg_write(REG_FCORR, fcorr);
    send(eval_item('0));
    send(eval_item('1));
    for (int i = 0; i < n; i++) begin
      if (hold && i == n / 2) hold_req = 1;
      send(random_item());
    end
    drain();
  endtask

  initial begin
    in_item_t it;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // fill every level before any evaluation, extremes in the first two
    for (int l = 0; l < 32; l++) begin
      it = level_item(5'(l));
      if (l == 0) begin
        it.corr_seed_low = '0; it.corr_seed_high = '0;
        it.corr_bit_left = 1'b0; it.corr_bit_right = 1'b0;
      end else if (l == 1) begin
        it.corr_seed_low = '1; it.corr_seed_high = '1;
        it.corr_bit_left = 1'b1; it.corr_bit_right = 1'b1;
      end
      send(it);
    end
    // reset configuration: depth one, modulus all ones
    send(eval_item('0));
    send(eval_item('1));
    send(eval_item(32'h8000_0000));
    send(eval_item(32'h0000_0001));
    drain();
    run_phase('0, '1, 1'b0, 6'd1, '1, '0, 110, 1'b0);
    run_phase('1, '1, 1'b1, 6'd32, '0, rand64(), 38, 1'b0);     // modulus zero, max depth
    run_phase(rand64(), rand64(), 1'b0, 6'd0, 64'd1, 64'd5, 100, 1'b0); // depth zero
    run_phase(rand64(), rand64(), 1'b1, 6'd63, rand64(), '1, 28, 1'b0); // saturated depth
    run_phase(rand64(), rand64(), 1'b0, 6'd4, 64'd1000, rand64(), 200, 1'b1);
    run_phase(rand64(), rand64(), 1'b1, 6'd8, rand64(), rand64() >> 1, 200, 1'b0);
    run_phase(rand64(), rand64(), 1'b0, 6'd2, rand64(), rand64(), 200, 1'b1);
    run_phase(rand64(), rand64(), 1'b1, 6'd3, '1, 64'hFFFF_FFFF_FFFF_FFFE, 180, 1'b0);
    run_phase(rand64(), rand64(), 1'b0, 6'd16, rand64(), rand64(), 80, 1'b0);
    repeat (1500) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("dpf_point_evaluation_tb OK");
    end else begin
      $display("dpf_point_evaluation_tb NOT OK");
    end
    $finish;
  end
endmodule
